@@ rtl/esu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esu_pkg
// shared types, character codes and digit decoding for the unescaper
// ----------------------------------------------------------------------------
package esu_pkg;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_X   = 8'h78;
  localparam logic [7:0] CH_D   = 8'h64;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam logic [1:0] HEX_DIGITS = 2'd2;
  localparam logic [1:0] DEC_DIGITS = 2'd3;

  // one queued entry: the result words caused by one input word
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic       v0;
    logic [7:0] b1;
    logic       eos;
  } esu_rec_t;

  // bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c inside {[8'h30:8'h39]}) r = {1'b0, 4'(c - 8'h30)};
    else if (c inside {[8'h61:8'h66]}) r = {1'b0, 4'(c - 8'h61 + 8'd10)};
    else if (c inside {[8'h41:8'h46]}) r = {1'b0, 4'(c - 8'h41 + 8'd10)};
    return r;
  endfunction

  // bit 4 set when the byte is not a decimal digit
  function automatic logic [4:0] dec_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c inside {[8'h30:8'h39]}) r = {1'b0, 4'(c - 8'h30)};
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/esu_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esu channel interfaces
// valid/ready channels for raw input words and unescaped result words
// ----------------------------------------------------------------------------
interface esu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;
  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface esu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_end;
  logic       last;
  modport source (output valid, output out_byte, output byte_valid, output string_end,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input string_end,
                  input last, output ready);
endinterface
`default_nettype wire

@@ rtl/esu_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esu_front
// escape parser: takes one raw word per cycle on fire, builds a queue entry
// ----------------------------------------------------------------------------
module esu_front
  import esu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire logic [7:0] c,
  input  wire logic     eos,
  output esu_rec_t      rec,
  output logic          push
);

  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam logic [1:0] MODE_DEC  = 2'd3;

  logic [1:0] mode_r, mode_nxt;
  logic [1:0] left_r, left_nxt;
  logic [7:0] val_r, val_nxt;

  always_comb begin
    logic [1:0] n;
    logic [7:0] b0, b1;
    logic [4:0] dv;
    logic [7:0] prod;
    logic [1:0] left_dec;
    n        = 2'd0;
    b0       = 8'h00;
    b1       = 8'h00;
    mode_nxt = mode_r;
    left_nxt = left_r;
    val_nxt  = val_r;
    dv       = (mode_r == MODE_HEX) ? hex_val(c) : dec_val(c);
    prod     = (mode_r == MODE_HEX) ? {val_r[3:0], 4'h0} : 8'({val_r, 3'b0} + {val_r, 1'b0});
    left_dec = (left_r != 2'd0) ? left_r - 2'd1 : 2'd0;
    case (mode_r)
      MODE_HEX, MODE_DEC: begin
        if (!dv[4]) begin
          val_nxt  = prod + {4'h0, dv[3:0]};
          left_nxt = left_dec;
          if (left_dec == 2'd0) begin
            b0       = val_nxt;
            n        = 2'd1;
            mode_nxt = MODE_TEXT;
          end
        end else begin
          b0       = val_r;
          n        = 2'd1;
          left_nxt = 2'd0;
          if (c == CH_BSL) begin
            mode_nxt = MODE_ESC;
          end else begin
            mode_nxt = MODE_TEXT;
            b1       = c;
            n        = 2'd2;
          end
        end
      end
      MODE_ESC: begin
        mode_nxt = MODE_TEXT;
        case (c)
          CH_N:   begin b0 = CH_LF;  n = 2'd1; end
          CH_R:   begin b0 = CH_CR;  n = 2'd1; end
          CH_T:   begin b0 = CH_TAB; n = 2'd1; end
          CH_BSL: begin b0 = CH_BSL; n = 2'd1; end
          CH_X: begin
            mode_nxt = MODE_HEX;
            left_nxt = HEX_DIGITS;
            val_nxt  = 8'h00;
          end
          CH_D: begin
            mode_nxt = MODE_DEC;
            left_nxt = DEC_DIGITS;
            val_nxt  = 8'h00;
          end
          default: ;
        endcase
      end
      default: begin
        if (c == CH_BSL) mode_nxt = MODE_ESC;
        else begin
          b0 = c;
          n  = 2'd1;
        end
      end
    endcase
    if (eos) begin
      // pending hex value is flushed at end of string
      if (mode_nxt == MODE_HEX) begin
        if (n == 2'd0) begin
          b0 = val_nxt;
          n  = 2'd1;
        end else begin
          b1 = val_nxt;
          n  = 2'd2;
        end
      end
      mode_nxt = MODE_TEXT;
      left_nxt = 2'd0;
      val_nxt  = 8'h00;
    end
    rec.two = (n == 2'd2);
    rec.b0  = b0;
    rec.v0  = (n != 2'd0);
    rec.b1  = b1;
    rec.eos = eos;
    push    = fire && ((n != 2'd0) || eos);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TEXT;
      left_r <= 2'd0;
      val_r  <= 8'h00;
    end else if (fire) begin
      mode_r <= mode_nxt;
      left_r <= left_nxt;
      val_r  <= val_nxt;
    end
  end

  a_number_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_HEX || mode_r == MODE_DEC) |-> left_r != 2'd0)
    else $error("number mode with no digits left");

endmodule
`default_nettype wire

@@ rtl/esu_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esu_queue
// two-entry queue between the parser and the output sequencer
// ----------------------------------------------------------------------------
module esu_queue
  import esu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire esu_rec_t wr_data,
  output logic          full,
  input  wire logic     pop,
  output esu_rec_t      head,
  output logic          empty
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  esu_rec_t        q_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= AW'(wr_ptr_r + 1'b1);
      if (pop)  rd_ptr_r <= AW'(rd_ptr_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= wr_data;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

@@ rtl/esu_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esu_back
// output sequencer: splits each queued entry into result words
// ----------------------------------------------------------------------------
module esu_back
  import esu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire esu_rec_t head,
  input  wire logic     empty,
  output logic          pop,
  esu_out_if.source     out_m
);

  logic       sel_r;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       bval_r, send_r, last_r;
  logic       load, fin;

  assign load = !out_valid_r || out_m.ready;
  assign fin  = sel_r || !head.two;
  assign pop  = load && !empty && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= !empty;
      if (!empty) sel_r <= !fin;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      byte_r <= sel_r ? head.b1 : head.b0;
      bval_r <= sel_r ? 1'b1 : head.v0;
      send_r <= head.eos && fin;
      last_r <= fin;
    end
  end

  assign out_m.valid      = out_valid_r;
  assign out_m.out_byte   = byte_r;
  assign out_m.byte_valid = bval_r;
  assign out_m.string_end = send_r;
  assign out_m.last       = last_r;

  a_second_part_queued: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> !empty && head.two)
    else $error("second word pending without a two-word entry");

endmodule
`default_nettype wire

@@ rtl/escape_sequence_unescaper_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escape_sequence_unescaper_core
// unescapes a backslash-escaped byte string; barring stalls, one word per cycle
// ----------------------------------------------------------------------------
// in_s carries one raw byte per word with end_of_string on the final byte.
// out_m carries unescaped bytes; last marks the final word caused by an input
// word, string_end the final word of a string, and byte_valid = 0 marks a bare
// end marker when the final input word yields no byte.
// the parser takes one input word per cycle whenever the two-entry queue has
// room; words that yield nothing mid-string leave no trace downstream.
// an accepted input word is written into the queue at the edge that accepts it,
// and the output register loads it from the queue head once that register is free.
// the output sequencer sends one word per cycle while out_m is ready,
// so an input word that yields two bytes (a number cut short by plain text)
// holds its queue entry until both words are sent, and sustained rate drops
// below one per cycle only by those extra words.
// out_m stalls are absorbed by the output register and the queue; once the
// queue is full in_s.ready drops until a word leaves.
// synchronous reset returns the parser to plain text and empties the queue and
// the output register.
// ----------------------------------------------------------------------------
module escape_sequence_unescaper_core
  import esu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  esu_in_if.sink    in_s,
  esu_out_if.source out_m
);

  esu_rec_t rec, head;
  logic     push, pop, full, empty, fire;

  assign in_s.ready = !full;
  assign fire       = in_s.valid && !full;

  esu_front u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .c    (in_s.in_byte),
    .eos  (in_s.end_of_string),
    .rec  (rec),
    .push (push)
  );

  esu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_data(rec),
    .full   (full),
    .pop    (pop),
    .head   (head),
    .empty  (empty)
  );

  esu_back u_back (
    .clk  (clk),
    .rst_n(rst_n),
    .head (head),
    .empty(empty),
    .pop  (pop),
    .out_m(out_m)
  );

endmodule
`default_nettype wire

@@ verif/escape_sequence_unescaper_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_sequence_unescaper_core_test
// self-checking bench for the escape-sequence unescaper: a directed table
// covers every escape, the byte extremes, numbers cut short or wrapped and
// each end-of-string case; random well-formed strings with noise follow.
// every accepted input word runs through a local unescape predictor and each
// result word is matched field by field against the oldest prediction, with
// random stalls on both channels.
// ----------------------------------------------------------------------------
module escape_sequence_unescaper_core_test
  import esu_pkg::*;
();

  typedef enum logic [1:0] {PM_TEXT, PM_ESC, PM_HEX, PM_DEC} parse_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       str_end;
    logic       tail;
  } unesc_word_t;

  typedef struct {
    logic [7:0]  c;
    logic        eos;
    logic        typed;
    unesc_word_t w;
  } stim_row_t;

  localparam unesc_word_t NO_WORD    = '0;
  localparam unesc_word_t END_MARKER = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam logic [4:0]  NOT_DIGIT  = 5'h10;
  localparam int          RANDOM_WORDS = 1900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic calm = 1'b0;
  logic held = 1'b0;
  int   errors = 0;
  int   words_sent = 0;

  parse_mode_e   pmode = PM_TEXT;
  logic [1:0]    digits_left = '0;
  logic [7:0]    num_val = '0;
  unesc_word_t   expected_words[$];

  esu_in_if  in_if();
  esu_out_if out_if();

  escape_sequence_unescaper_core dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_if),
    .out_m(out_if)
  );

  always #1 clk = ~clk;

  stim_row_t directed_rows[$] = '{
    '{8'h00,  1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
    '{CH_BSL, 1'b0, 1'b0, NO_WORD},
    '{CH_N,   1'b0, 1'b1, '{CH_LF, 1'b1, 1'b0, 1'b1}},
    '{CH_BSL, 1'b0, 1'b0, NO_WORD},
    '{CH_R,   1'b0, 1'b1, '{CH_CR, 1'b1, 1'b0, 1'b1}},
    '{CH_BSL, 1'b0, 1'b0, NO_WORD},
    '{CH_T,   1'b0, 1'b1, '{CH_TAB, 1'b1, 1'b0, 1'b1}},
    '{CH_BSL, 1'b0, 1'b0, NO_WORD},
    '{CH_BSL, 1'b0, 1'b1, '{CH_BSL, 1'b1, 1'b0, 1'b1}},
    '{CH_BSL, 1'b0, 1'b0, NO_WORD},
    '{8'h71,  1'b0, 1'b0, NO_WORD},
    '{CH_BSL, 1'b0, 1'b0, NO_WORD},
    '{CH_X,   1'b0, 1'b0, NO_WORD},
    '{8'h46,  1'b0, 1'b0, NO_WORD},
    '{8'h66,  1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b1}},
    '{CH_BSL, 1'b0, 1'b0, NO_WORD},
    '{CH_D,   1'b0, 1'b0, NO_WORD},
    '{8'h32,  1'b0, 1'b0, NO_WORD},
    '{8'h35,  1'b0, 1'b0, NO_WORD},
    '{8'h36,  1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
    '{CH_BSL, 1'b0, 1'b0, NO_WORD},
    '{CH_X,   1'b0, 1'b0, NO_WORD},
    '{8'h37,  1'b0, 1'b0, NO_WORD},
    '{8'h5A,  1'b1, 1'b0, NO_WORD},
    '{CH_BSL, 1'b0, 1'b0, NO_WORD},
    '{CH_D,   1'b0, 1'b0, NO_WORD},
    '{8'h31,  1'b1, 1'b1, END_MARKER},
    '{CH_BSL, 1'b0, 1'b0, NO_WORD},
    '{CH_X,   1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}},
    '{CH_BSL, 1'b1, 1'b1, END_MARKER},
    '{8'hFF,  1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1}}
  };

  function automatic void unescape_word(input logic [7:0] c, input logic eos);
    logic [7:0]  got[$];
    logic [4:0]  dig;
    logic        plain;
    unesc_word_t w;
    plain = 1'b0;
    case (pmode)
      PM_HEX, PM_DEC: begin
        dig = NOT_DIGIT;
        if (c >= 8'h30 && c <= 8'h39) dig = 5'(c - 8'h30);
        else if (pmode == PM_HEX && c >= 8'h61 && c <= 8'h66) dig = 5'(c - 8'h61 + 8'd10);
        else if (pmode == PM_HEX && c >= 8'h41 && c <= 8'h46) dig = 5'(c - 8'h41 + 8'd10);
        if (dig != NOT_DIGIT) begin
          num_val = 8'(num_val * ((pmode == PM_HEX) ? 16 : 10) + dig);
          if (digits_left != 0) digits_left = digits_left - 1'b1;
          if (digits_left == 0) begin
            got.push_back(num_val);
            pmode = PM_TEXT;
          end
        end else begin
          // number cut short: flush value, then the byte is plain text
          got.push_back(num_val);
          pmode = PM_TEXT;
          digits_left = '0;
          plain = 1'b1;
        end
      end
      PM_ESC: begin
        pmode = PM_TEXT;
        case (c)
          CH_N:   got.push_back(CH_LF);
          CH_R:   got.push_back(CH_CR);
          CH_T:   got.push_back(CH_TAB);
          CH_BSL: got.push_back(CH_BSL);
          CH_X: begin
            pmode = PM_HEX;
            digits_left = HEX_DIGITS;
            num_val = '0;
          end
          CH_D: begin
            pmode = PM_DEC;
            digits_left = DEC_DIGITS;
            num_val = '0;
          end
          default: ;
        endcase
      end
      default: plain = 1'b1;
    endcase
    if (plain) begin
      if (c == CH_BSL) pmode = PM_ESC;
      else got.push_back(c);
    end
    if (eos) begin
      if (pmode == PM_HEX) got.push_back(num_val);
      pmode = PM_TEXT;
      digits_left = '0;
      num_val = '0;
      if (got.size() == 0) begin
        expected_words.push_back(END_MARKER);
        return;
      end
    end
    foreach (got[k]) begin
      w.data     = got[k];
      w.has_byte = 1'b1;
      w.tail     = (k == got.size() - 1);
      w.str_end  = eos && w.tail;
      expected_words.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what, input unesc_word_t got,
                                 input unesc_word_t want);
    errors++;
    $display("%0t mismatch %s: got %h/%b/%b/%b want %h/%b/%b/%b", $realtime, what,
             got.data, got.has_byte, got.str_end, got.tail,
             want.data, want.has_byte, want.str_end, want.tail);
  endtask

  // caller enters at a falling edge; returns at the falling edge after accept
  task automatic push_word(input logic [7:0] c, input logic eos, input logic typed,
                           input unesc_word_t w);
    int n0;
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.in_byte       <= c;
    in_if.end_of_string <= eos;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    n0 = expected_words.size();
    unescape_word(c, eos);
    if (typed) begin
      while (expected_words.size() > n0) void'(expected_words.pop_back());
      expected_words.push_back(w);
    end
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  task automatic send_random_string();
    logic [7:0] txt[$];
    logic [7:0] c;
    int tokens;
    int k;
    tokens = $urandom_range(1, 8);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        4: begin
          txt.push_back(CH_BSL);
          case ($urandom_range(0, 3))
            0: txt.push_back(CH_N);
            1: txt.push_back(CH_R);
            2: txt.push_back(CH_T);
            default: txt.push_back(CH_BSL);
          endcase
        end
        5: begin
          txt.push_back(CH_BSL);
          txt.push_back(CH_X);
          k = $urandom_range(0, 2);
          repeat (k) txt.push_back(hex_char(4'($urandom_range(0, 15))));
        end
        6: begin
          txt.push_back(CH_BSL);
          txt.push_back(CH_D);
          k = $urandom_range(0, 3);
          repeat (k) txt.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end
        7: begin
          txt.push_back(CH_BSL);
          txt.push_back(8'($urandom_range(0, 255)));
        end
        8: txt.push_back(8'($urandom_range(0, 255)));
        default: begin
          c = 8'($urandom_range(0, 255));
          txt.push_back((c == CH_BSL) ? 8'h41 : c);
        end
      endcase
    end
    foreach (txt[i]) begin
      calm = (words_sent >= 800 && words_sent < 1100);
      push_word(txt[i], i == txt.size() - 1, 1'b0, NO_WORD);
    end
  endtask

  always @(negedge clk) begin
    out_if.ready <= calm || ($urandom_range(0, 99) >= 17);
  end

  always @(posedge clk) begin
    unesc_word_t got;
    unesc_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.out_byte, out_if.byte_valid, out_if.string_end, out_if.last};
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", got, NO_WORD);
      end else begin
        want = expected_words.pop_front();
        if (got.has_byte !== want.has_byte) report_mismatch("byte_valid", got, want);
        if (got.data !== want.data) report_mismatch("out_byte", got, want);
        if (got.str_end !== want.str_end) report_mismatch("string_end", got, want);
        if (got.tail !== want.tail) report_mismatch("last", got, want);
      end
    end
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.in_byte       = '0;
    in_if.end_of_string = 1'b0;
    out_if.ready        = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_rows[i]) begin
      push_word(directed_rows[i].c, directed_rows[i].eos, directed_rows[i].typed,
                directed_rows[i].w);
    end
    drain_results();
    while (words_sent < RANDOM_WORDS) begin
      send_random_string();
      // hold the sender once mid-run until the output side has caught up
      if (!held && words_sent >= 1300) begin
        drain_results();
        held = 1'b1;
      end
    end
    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule
